### sv/wsdf_pkg.sv
// Package for the WebSocket frame deframer: result codes, opcodes and the
// front-to-back queue entry type. Depends on nothing.
package wsdf_pkg;

	localparam logic [2:0] CODE_DATA       = 3'd0;
	localparam logic [2:0] CODE_PING       = 3'd1;
	localparam logic [2:0] CODE_EMPTY_DATA = 3'd2;
	localparam logic [2:0] CODE_EMPTY_PING = 3'd3;
	localparam logic [2:0] CODE_CLOSE      = 3'd4;
	localparam logic [2:0] CODE_PROTO      = 3'd5;
	localparam logic [2:0] CODE_TOO_LARGE  = 3'd6;

	localparam logic [3:0] OP_CONT  = 4'd0;
	localparam logic [3:0] OP_TEXT  = 4'd1;
	localparam logic [3:0] OP_BIN   = 4'd2;
	localparam logic [3:0] OP_CLOSE = 4'd8;
	localparam logic [3:0] OP_PING  = 4'd9;

	localparam logic [31:0] MAX_LEN_RESET = 32'd65000;
	localparam logic [6:0]  CTRL_MAX_LEN  = 7'd125;

	// One classified result on its way to the output stage.
	typedef struct packed {
		logic [2:0] code;
		logic [7:0] data;
		logic       is_text;
		logic       frame_end;
		logic       message_end;
	} wsdf_res_t;

endpackage

### sv/wsdf_front.sv
// Front part of the deframer: header parsing, length checks and unmasking.
// Depends on wsdf_pkg. Produces at most one result request per byte.
module wsdf_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 byte_valid,
	input  logic [7:0]           byte_data,
	input  logic [31:0]          max_len,
	output logic                 res_valid,
	output wsdf_pkg::wsdf_res_t  res
);

	typedef enum logic [2:0] {
		PH_HDR0, PH_HDR1, PH_EXTLEN, PH_MASK, PH_PAYLOAD
	} phase_t;

	phase_t      phase_q;
	logic [3:0]  opcode_q;
	logic        final_q;
	logic [3:0]  lenleft_q;
	logic [63:0] remain_q;
	logic [31:0] key_q;
	logic [1:0]  keypos_q;
	logic [1:0]  frag_q;
	logic [31:0] msglen_q;
	logic        closed_q;

	// Next-state values
	phase_t      phase_d;
	logic [3:0]  opcode_d;
	logic        final_d;
	logic [3:0]  lenleft_d;
	logic [63:0] remain_d;
	logic [31:0] key_d;
	logic [1:0]  keypos_d;
	logic [1:0]  frag_d;
	logic [31:0] msglen_d;
	logic        closed_d;
	logic        emit;
	wsdf_pkg::wsdf_res_t r;

	logic [3:0]  op_in;
	logic        fin_in;
	logic [63:0] len_cand;
	logic        len_complete;
	logic        op_is_data;
	logic [64:0] total;
	logic [7:0]  keyb;
	logic        last;

	always_comb begin
		op_in  = byte_data[3:0];
		fin_in = byte_data[7];
		phase_d = phase_q; opcode_d = opcode_q; final_d = final_q;
		lenleft_d = lenleft_q; remain_d = remain_q; key_d = key_q;
		keypos_d = keypos_q; frag_d = frag_q; msglen_d = msglen_q;
		closed_d = closed_q;
		emit = 1'b0;
		r = '0;
		len_cand = 64'd0;
		len_complete = 1'b0;
		op_is_data = (opcode_q <= wsdf_pkg::OP_BIN);
		keyb = 8'd0;
		last = 1'b0;
		total = 65'd0;
		if (byte_valid && !closed_q) begin
			case (phase_q)
				PH_HDR0: begin
					if ((byte_data[6:4] != 3'd0)
						|| (op_in >= 4'd3 && op_in <= 4'd7) || op_in >= 4'd11
						|| (op_in >= 4'd8 && !fin_in)
						|| (op_in == wsdf_pkg::OP_CONT && frag_q == 2'd0)
						|| ((op_in == wsdf_pkg::OP_TEXT || op_in == wsdf_pkg::OP_BIN)
							&& frag_q != 2'd0)) begin
						emit = 1'b1; r.code = wsdf_pkg::CODE_PROTO;
					end else begin
						opcode_d = op_in; final_d = fin_in; phase_d = PH_HDR1;
					end
				end
				PH_HDR1: begin
					remain_d = 64'd0;
					if (!byte_data[7]) begin
						emit = 1'b1; r.code = wsdf_pkg::CODE_PROTO;
					end else if (byte_data[6:0] == 7'd126) begin
						lenleft_d = 4'd2; phase_d = PH_EXTLEN;
					end else if (byte_data[6:0] == 7'd127) begin
						lenleft_d = 4'd8; phase_d = PH_EXTLEN;
					end else begin
						len_cand = {57'd0, byte_data[6:0]};
						len_complete = 1'b1;
					end
				end
				PH_EXTLEN: begin
					if (lenleft_q == 4'd8 && byte_data[7]) begin
						emit = 1'b1; r.code = wsdf_pkg::CODE_PROTO;
					end else begin
						remain_d = {remain_q[55:0], byte_data};
						lenleft_d = lenleft_q - 4'd1;
						if (lenleft_q == 4'd1) begin
							len_cand = remain_d;
							len_complete = 1'b1;
						end
					end
				end
				PH_MASK: begin
					key_d = {key_q[23:0], byte_data};
					lenleft_d = lenleft_q - 4'd1;
					if (lenleft_q == 4'd1) begin
						keypos_d = 2'd0;
						phase_d = PH_HDR0;
						if (remain_q != 64'd0) phase_d = PH_PAYLOAD;
						else if (op_is_data) begin
							emit = 1'b1; r.code = wsdf_pkg::CODE_EMPTY_DATA;
							r.is_text = (opcode_q == wsdf_pkg::OP_TEXT);
							r.frame_end = 1'b1; r.message_end = final_q;
						end else if (opcode_q == wsdf_pkg::OP_PING) begin
							emit = 1'b1; r.code = wsdf_pkg::CODE_EMPTY_PING;
							r.frame_end = 1'b1; r.message_end = 1'b1;
						end else if (opcode_q == wsdf_pkg::OP_CLOSE) begin
							emit = 1'b1; r.code = wsdf_pkg::CODE_CLOSE;
							r.frame_end = 1'b1; r.message_end = 1'b1;
							closed_d = 1'b1;
						end
					end
				end
				PH_PAYLOAD: begin
					case (keypos_q)
						2'd0: keyb = key_q[31:24];
						2'd1: keyb = key_q[23:16];
						2'd2: keyb = key_q[15:8];
						default: keyb = key_q[7:0];
					endcase
					keypos_d = keypos_q + 2'd1;
					remain_d = remain_q - 64'd1;
					last = (remain_q == 64'd1);
					if (last) phase_d = PH_HDR0;
					if (op_is_data) begin
						emit = 1'b1; r.code = wsdf_pkg::CODE_DATA;
						r.data = byte_data ^ keyb;
						r.is_text = (opcode_q == wsdf_pkg::OP_TEXT);
						r.frame_end = last; r.message_end = last && final_q;
					end else if (opcode_q == wsdf_pkg::OP_PING) begin
						emit = 1'b1; r.code = wsdf_pkg::CODE_PING;
						r.data = byte_data ^ keyb;
						r.frame_end = last; r.message_end = last;
					end else if (opcode_q == wsdf_pkg::OP_CLOSE && last) begin
						emit = 1'b1; r.code = wsdf_pkg::CODE_CLOSE;
						r.frame_end = 1'b1; r.message_end = 1'b1;
						closed_d = 1'b1;
					end
				end
				default: phase_d = PH_HDR0;
			endcase
			// Length complete: size checks and message bookkeeping.
			if (len_complete) begin
				if (op_is_data) begin
					total = {1'b0, len_cand}
						+ ((opcode_q == wsdf_pkg::OP_CONT) ? {33'd0, msglen_q} : 65'd0);
					if (total > {33'd0, max_len}) begin
						emit = 1'b1; r.code = wsdf_pkg::CODE_TOO_LARGE;
					end else begin
						if (opcode_q == wsdf_pkg::OP_CONT) opcode_d = {2'b00, frag_q};
						if (final_q) begin
							frag_d = 2'd0; msglen_d = 32'd0;
						end else begin
							frag_d = (opcode_q == wsdf_pkg::OP_CONT) ? frag_q : opcode_q[1:0];
							msglen_d = total[31:0];
						end
					end
				end else if (len_cand > {32'd0, max_len}) begin
					emit = 1'b1; r.code = wsdf_pkg::CODE_TOO_LARGE;
				end else if (len_cand > {57'd0, wsdf_pkg::CTRL_MAX_LEN}) begin
					emit = 1'b1; r.code = wsdf_pkg::CODE_PROTO;
				end
				if (!emit) begin
					remain_d = len_cand; phase_d = PH_MASK;
					lenleft_d = 4'd4; key_d = 32'd0;
				end
			end
			if (emit && (r.code == wsdf_pkg::CODE_PROTO
				|| r.code == wsdf_pkg::CODE_TOO_LARGE))
				closed_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0; opcode_q <= '0; final_q <= 1'b0;
			lenleft_q <= '0; remain_q <= '0; key_q <= '0; keypos_q <= '0;
			frag_q <= '0; msglen_q <= '0; closed_q <= 1'b0;
			res_valid <= 1'b0; res <= '0;
		end else begin
			phase_q <= phase_d; opcode_q <= opcode_d; final_q <= final_d;
			lenleft_q <= lenleft_d; remain_q <= remain_d; key_q <= key_d;
			keypos_q <= keypos_d; frag_q <= frag_d; msglen_q <= msglen_d;
			closed_q <= closed_d;
			res_valid <= emit;
			res <= r;
		end
	end

`ifndef SYNTHESIS
	a_closed_stays: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q |=> closed_q) else $error("closed flag dropped");
	a_no_result_closed: assert property (@(posedge clk) disable iff (!arst_n)
		$past(closed_q) |-> !res_valid) else $error("result after close");
	a_error_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (res.code == wsdf_pkg::CODE_PROTO
			|| res.code == wsdf_pkg::CODE_TOO_LARGE)) |-> closed_q)
		else $error("error did not close");
`endif

endmodule

### sv/wsdf_queue.sv
// Short result queue between front and back parts, read straight from its entries.
// Depends on wsdf_pkg. Depth fixed at four entries.
module wsdf_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr_valid,
	input  wsdf_pkg::wsdf_res_t  wr_res,
	output logic [2:0]           count,
	output logic                 rd_valid,
	input  logic                 rd_ready,
	output wsdf_pkg::wsdf_res_t  rd_res
);

	wsdf_pkg::wsdf_res_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pop      = rd_ready && cnt_q != 3'd0;
	assign rd_valid = cnt_q != 3'd0;
	assign rd_res   = mem_q[rp_q];
	assign count    = cnt_q;

	always_ff @(posedge clk) begin
		if (wr_valid) mem_q[wp_q] <= wr_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr_valid) wp_q <= wp_q + 2'd1;
			if (pop) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr_valid} - {2'd0, pop};
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 3'd4) else $error("queue overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 3'd4) |-> !wr_valid) else $error("push into full queue");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_valid && !pop) |=> cnt_q == $past(cnt_q) + 3'd1)
		else $error("count step wrong");
`endif

endmodule

### sv/websocket_frame_deframer_core.sv
// Top level of the WebSocket client-to-server frame deframer.
// Depends on wsdf_pkg, wsdf_front and wsdf_queue.
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[7:0] in_byte
//  m_axis    out        tdata[7:0] out_byte, tdata[8] message_end;
//                       tuser[2:0] code, tuser[3] is_text; tlast frame_end
//  cfg       in         cfg_data[31:0] max_message_length
//
// One byte is taken per cycle while s_axis_tready is high; the front part
// registers its result, which is then written into a four-entry queue and
// offered on m_axis from there.
// s_axis_tready is low while the queue count plus the pending front result
// exceeds two, so every accepted byte is sure of a free queue entry.
// Reset is asynchronous and active low; the limit register resets to 65000.
// After a close or an error every byte is accepted and discarded.
module websocket_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // out_byte[7:0], message_end, zero fill
	output logic [3:0]  m_axis_tuser,   // out_code[2:0], is_text
	output logic        m_axis_tlast,   // frame_end
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic [31:0] max_len_q;
	logic        res_valid;
	logic [2:0]  count;
	wsdf_pkg::wsdf_res_t res, out_res;

	// Limit register; users send writes only while the block is idle; unchecked.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) max_len_q <= wsdf_pkg::MAX_LEN_RESET;
		else if (cfg_valid) max_len_q <= cfg_data;
	end

	// Room for the result in flight in the front register plus this byte.
	assign s_axis_tready = ({2'd0, res_valid} + count) <= 3'd2;

	wsdf_front u_front (
		.clk(clk), .arst_n(arst_n),
		.byte_valid(s_axis_tvalid && s_axis_tready),
		.byte_data(s_axis_tdata), .max_len(max_len_q),
		.res_valid(res_valid), .res(res)
	);

	wsdf_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(res_valid), .wr_res(res), .count(count),
		.rd_valid(m_axis_tvalid), .rd_ready(m_axis_tready), .rd_res(out_res)
	);

	assign m_axis_tdata = {7'd0, out_res.message_end, out_res.data};
	assign m_axis_tuser = {out_res.is_text, out_res.code};
	assign m_axis_tlast = out_res.frame_end;

`ifndef SYNTHESIS
	a_out_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[2:0] != 3'd7) else $error("bad code");
	a_err_flags: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser[2:0] == wsdf_pkg::CODE_PROTO
			|| m_axis_tuser[2:0] == wsdf_pkg::CODE_TOO_LARGE))
		|-> {m_axis_tdata[8], m_axis_tlast, m_axis_tuser[3]} == 3'd0)
		else $error("error with marks");
	a_msg_implies_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[8]) |-> m_axis_tlast)
		else $error("message end without frame end");
`endif

endmodule

### tb/websocket_frame_deframer_core_tb.sv
// Self-checking testbench for websocket_frame_deframer_core: builds masked client
// frames, predicts every output request and compares them field by field.
// Depends on wsdf_pkg and the deframer RTL.
module websocket_frame_deframer_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // in_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // out_byte[7:0], message_end, zero fill
	logic [3:0]  m_axis_tuser;   // code[2:0], is_text
	logic        m_axis_tlast;   // frame_end
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	websocket_frame_deframer_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	// Predicted deframer state, held in fields that mirror the hardware.
	typedef enum logic [3:0] {
		PH_HDR0 = 4'd0, PH_HDR1 = 4'd1, PH_EXTLEN = 4'd2, PH_KEY = 4'd3, PH_PAYLOAD = 4'd4
	} phase_t;

	logic [31:0] lim;
	phase_t      ph;
	logic [3:0]  cur_op;
	logic        cur_fin;
	logic [3:0]  bytes_due;
	logic [63:0] pay_left;
	logic [31:0] key;
	logic [1:0]  key_pos;
	logic [1:0]  frag_kind;
	logic [31:0] msg_len;
	logic        closed;

	wsdf_pkg::wsdf_res_t expected_q[$];
	int unsigned mismatches = 0;
	longint      cycles = 0;
	logic        stall_out;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd2000000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	function automatic void push_res(logic [2:0] c, logic [7:0] d, logic t, logic fe,
		logic me);
		wsdf_pkg::wsdf_res_t r;
		r.code = c; r.data = d; r.is_text = t; r.frame_end = fe; r.message_end = me;
		expected_q.push_back(r);
	endfunction

	function automatic void fail_with(logic [2:0] c);
		closed = 1'b1;
		push_res(c, 8'd0, 1'b0, 1'b0, 1'b0);
	endfunction

	function automatic void predict_reset();
		lim = wsdf_pkg::MAX_LEN_RESET; ph = PH_HDR0; cur_op = '0; cur_fin = 1'b0;
		bytes_due = '0; pay_left = '0; key = '0; key_pos = '0; frag_kind = '0;
		msg_len = '0; closed = 1'b0;
	endfunction

	// Called once the payload length is fully known.
	function automatic void length_known();
		logic [63:0] total;
		total = pay_left;
		if (cur_op <= wsdf_pkg::OP_BIN) begin
			if (cur_op == wsdf_pkg::OP_CONT) total += {32'd0, msg_len};
			if (total > {32'd0, lim}) begin
				fail_with(wsdf_pkg::CODE_TOO_LARGE);
				return;
			end
			if (cur_op == wsdf_pkg::OP_CONT) cur_op = {2'b00, frag_kind};
			if (cur_fin) begin
				frag_kind = 2'd0; msg_len = 32'd0;
			end else begin
				frag_kind = cur_op[1:0]; msg_len = total[31:0];
			end
		end else begin
			if (pay_left > {32'd0, lim}) begin
				fail_with(wsdf_pkg::CODE_TOO_LARGE);
				return;
			end
			if (pay_left > 64'd125) begin
				fail_with(wsdf_pkg::CODE_PROTO);
				return;
			end
		end
		ph = PH_KEY; bytes_due = 4'd4; key = 32'd0;
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		logic [3:0] op;
		logic [7:0] ub;
		logic       last;
		if (closed) return;
		case (ph)
			PH_HDR0: begin
				op = b[3:0];
				if (b[6:4] != 3'd0) fail_with(wsdf_pkg::CODE_PROTO);
				else if ((op >= 4'd3 && op <= 4'd7) || op >= 4'd11)
					fail_with(wsdf_pkg::CODE_PROTO);
				else if (op >= wsdf_pkg::OP_CLOSE && !b[7]) fail_with(wsdf_pkg::CODE_PROTO);
				else if (op == wsdf_pkg::OP_CONT && frag_kind == 2'd0)
					fail_with(wsdf_pkg::CODE_PROTO);
				else if ((op == wsdf_pkg::OP_TEXT || op == wsdf_pkg::OP_BIN)
					&& frag_kind != 2'd0)
					fail_with(wsdf_pkg::CODE_PROTO);
				else begin
					cur_op = op; cur_fin = b[7]; ph = PH_HDR1;
				end
			end
			PH_HDR1: begin
				if (!b[7]) fail_with(wsdf_pkg::CODE_PROTO);
				else begin
					pay_left = 64'd0;
					if (b[6:0] == 7'd126) begin
						bytes_due = 4'd2; ph = PH_EXTLEN;
					end else if (b[6:0] == 7'd127) begin
						bytes_due = 4'd8; ph = PH_EXTLEN;
					end else begin
						pay_left = {57'd0, b[6:0]};
						length_known();
					end
				end
			end
			PH_EXTLEN: begin
				if (bytes_due == 4'd8 && b[7]) fail_with(wsdf_pkg::CODE_PROTO);
				else begin
					pay_left = {pay_left[55:0], b};
					if (bytes_due > 4'd0) bytes_due--;
					if (bytes_due == 4'd0) length_known();
				end
			end
			PH_KEY: begin
				key = {key[23:0], b};
				if (bytes_due > 4'd0) bytes_due--;
				if (bytes_due == 4'd0) begin
					key_pos = 2'd0; ph = PH_PAYLOAD;
					if (pay_left == 64'd0) begin
						ph = PH_HDR0;
						if (cur_op <= wsdf_pkg::OP_BIN)
							push_res(wsdf_pkg::CODE_EMPTY_DATA, 8'd0,
								cur_op == wsdf_pkg::OP_TEXT, 1'b1, cur_fin);
						else if (cur_op == wsdf_pkg::OP_PING)
							push_res(wsdf_pkg::CODE_EMPTY_PING, 8'd0, 1'b0, 1'b1, 1'b1);
						else if (cur_op == wsdf_pkg::OP_CLOSE) begin
							closed = 1'b1;
							push_res(wsdf_pkg::CODE_CLOSE, 8'd0, 1'b0, 1'b1, 1'b1);
						end
					end
				end
			end
			PH_PAYLOAD: begin
				ub = b ^ key[31 - 8 * key_pos -: 8];
				key_pos++;
				if (pay_left > 64'd0) pay_left--;
				last = (pay_left == 64'd0);
				if (last) ph = PH_HDR0;
				if (cur_op <= wsdf_pkg::OP_BIN)
					push_res(wsdf_pkg::CODE_DATA, ub, cur_op == wsdf_pkg::OP_TEXT, last,
						last && cur_fin);
				else if (cur_op == wsdf_pkg::OP_PING)
					push_res(wsdf_pkg::CODE_PING, ub, 1'b0, last, last);
				else if (cur_op == wsdf_pkg::OP_CLOSE && last) begin
					closed = 1'b1;
					push_res(wsdf_pkg::CODE_CLOSE, 8'd0, 1'b0, 1'b1, 1'b1);
				end
			end
			default: ph = PH_HDR0;
		endcase
	endfunction

	// Output: random stalls once stall_out is set; taken requests checked in order.
	always @(posedge clk) begin
		wsdf_pkg::wsdf_res_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected output request code=%0d byte=%02h",
							m_axis_tuser[2:0], m_axis_tdata[7:0]);
				end else begin
					want = expected_q.pop_front();
					if (m_axis_tuser[2:0] !== want.code ||
						m_axis_tdata[7:0] !== want.data ||
						m_axis_tuser[3] !== want.is_text ||
						m_axis_tlast !== want.frame_end ||
						m_axis_tdata[8] !== want.message_end) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: want c%0d %02h t%0b f%0b m%0b %s",
								want.code, want.data, want.is_text, want.frame_end,
								want.message_end,
								$sformatf("got c%0d %02h t%0b f%0b m%0b",
									m_axis_tuser[2:0], m_axis_tdata[7:0],
									m_axis_tuser[3], m_axis_tlast, m_axis_tdata[8]));
					end
				end
			end
			if (stall_out)
				m_axis_tready <= ($urandom_range(0, 99) < 55);
			else
				m_axis_tready <= 1'b1;
		end
	end

	// Random idle gap before a request: mostly short, now and then long.
	function automatic int gap_len();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) n = 0;
		return n;
	endfunction

	// The valid line stays high between back-to-back requests and drops only
	// for a gap or a drain, so it never takes two assignments in one time step.
	task automatic send_byte(logic [7:0] b);
		int n;
		n = gap_len();
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		predict_byte(b);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		lim = v;
	endtask

	// A closed or failed connection stays dead, so reopening would need a reset;
	// instead the run is kept alive by avoiding terminal frames except at the end.
	task automatic send_frame(logic fin, logic [3:0] op, int unsigned len, int lenform);
		logic [31:0] k;
		k = $urandom();
		send_byte({fin, 3'b000, op});
		if (lenform == 0 && len < 126) send_byte({1'b1, 7'(len)});
		else if (lenform <= 1 && len < 65536) begin
			send_byte(8'hFE); send_byte(8'(len >> 8)); send_byte(8'(len));
		end else begin
			send_byte(8'hFF);
			for (int i = 7; i >= 0; i--)
				send_byte((i >= 4) ? 8'h00 : 8'(len >> (8 * i)));
		end
		for (int i = 0; i < 4; i++) send_byte(k[31 - 8 * i -: 8]);
		for (int unsigned i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
	endtask

	task automatic random_message();
		int nfrag;
		logic [3:0] kind;
		kind = $urandom_range(0, 1) ? wsdf_pkg::OP_TEXT : wsdf_pkg::OP_BIN;
		nfrag = $urandom_range(1, 3);
		for (int f = 0; f < nfrag; f++) begin
			if (f > 0 && $urandom_range(0, 3) == 0)
				send_frame(1'b1, $urandom_range(0, 1) ? wsdf_pkg::OP_PING : 4'hA,
					$urandom_range(0, 6), $urandom_range(0, 2));
			send_frame(f == nfrag - 1, (f == 0) ? kind : wsdf_pkg::OP_CONT,
				($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6),
				$urandom_range(0, 2));
		end
	endtask

	task automatic test_directed();
		send_frame(1'b1, wsdf_pkg::OP_TEXT, 0, 0);
		send_frame(1'b1, wsdf_pkg::OP_BIN, 3, 1);
		send_frame(1'b1, wsdf_pkg::OP_PING, 0, 0);
		send_frame(1'b1, wsdf_pkg::OP_PING, 125, 0);
		send_frame(1'b1, 4'hA, 0, 0);
		send_frame(1'b1, 4'hA, 2, 2);
		send_frame(1'b0, wsdf_pkg::OP_TEXT, 2, 0);
		send_frame(1'b1, wsdf_pkg::OP_PING, 1, 0);
		send_frame(1'b1, wsdf_pkg::OP_CONT, 130, 1);
	endtask

	task automatic test_limits();
		write_limit(32'd5);
		send_frame(1'b0, wsdf_pkg::OP_BIN, 3, 0);
		send_frame(1'b1, wsdf_pkg::OP_CONT, 2, 2);
		write_limit(32'hFFFF_FFFF);
		send_frame(1'b1, wsdf_pkg::OP_BIN, 4, 2);
		write_limit(32'd1);
		send_frame(1'b1, wsdf_pkg::OP_TEXT, 1, 0);
		write_limit(32'd200);
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 50; i++) begin
			random_message();
			if (i == 25) drain();
		end
	endtask

	// Finishes the connection with one of the terminal cases, then sends noise.
	task automatic test_termination();
		case ($urandom_range(0, 8))
			0: send_frame(1'b1, wsdf_pkg::OP_CLOSE, 0, 0);
			1: send_frame(1'b1, wsdf_pkg::OP_CLOSE, 3, 0);
			2: send_byte(8'hF1);
			3: send_byte({1'b1, 3'b000, 4'($urandom_range(3, 7))});
			4: send_byte(8'h08);
			5: send_byte(8'h80);
			6: begin send_byte(8'h82); send_byte(8'h05); end
			7: begin send_byte(8'h82); send_byte(8'hFF); send_byte(8'h80); end
			default: begin send_byte(8'h89); send_byte(8'hFE);
				send_byte(8'h00); send_byte(8'hC8); end
		endcase
		for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(0, 255)));
	endtask

	initial begin
		arst_n = 1'b0;
		stall_out = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		predict_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		stall_out = 1'b1;
		test_limits();
		test_random_traffic();
		test_termination();
		drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_q.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

### sim.f
sv/wsdf_pkg.sv
sv/wsdf_front.sv
sv/wsdf_queue.sv
sv/websocket_frame_deframer_core.sv
tb/websocket_frame_deframer_core_tb.sv
